### rtl/amo_near_far_predictor_macros.svh
// Assertion helpers used by the RTL checker file.
`ifndef AMO_NEAR_FAR_PREDICTOR_MACROS_SVH
`define AMO_NEAR_FAR_PREDICTOR_MACROS_SVH

// Checked only outside reset.
`define AMONF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define AMONF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/amonf_pkg.sv
package amonf_pkg;

  localparam int ADDR_BITS       = 48;
  localparam int DEF_SETS        = 64;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_CONF_BITS   = 2;
  localparam int DEF_TOTAL_BITS  = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int OFFSET_W        = 5;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd6;
  localparam logic [OFFSET_W-1:0] OFFSET_MIN   = 5'd1;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 5'd16;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_HIT     = 2'd1;
  localparam logic [1:0] MODE_EVICT   = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] L1_INVALID   = 2'd0;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] address;
    logic [1:0]           l1_state;
  } in_item_t;

  typedef struct packed {
    logic near;
    logic table_hit;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

### rtl/amonf_front.sv
module amonf_front import amonf_pkg::*; #(
  parameter int SETS = DEF_SETS,
  localparam int TAG_W = ADDR_BITS - 1,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int QW = 3 + TAG_W + SET_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OFFSET_W-1:0] offset,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                push,
  input  logic                full,
  output logic [QW-1:0]       push_data
);

  localparam bit   SETS_POW2 = (SETS & (SETS - 1)) == 0;
  localparam int   DIG       = 4;
  localparam int   STEPS     = (TAG_W + DIG - 1) / DIG;
  localparam int   TSH_W     = STEPS * DIG;
  localparam int   PART_W    = SET_W + DIG;
  localparam int   CNT_W     = $clog2(STEPS + 1);

  logic [OFFSET_W-1:0]  sh;
  logic [ADDR_BITS-1:0] shifted;
  logic [TAG_W-1:0]     tag;
  logic                 accept;
  logic                 keep;

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SET_W-1:0]     rem_r, rem_nxt;
  logic [TSH_W-1:0]     tsh_r, tsh_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 l1_r, l1_nxt;
  logic [PART_W-1:0]    part;

  always_comb begin
    if (offset < OFFSET_MIN) begin
      sh = OFFSET_MIN;
    end else if (offset > OFFSET_MAX) begin
      sh = OFFSET_MAX;
    end else begin
      sh = offset;
    end
  end

  assign shifted  = in_data.address >> sh;
  assign tag      = shifted[TAG_W-1:0];
  assign in_stall = busy_r || full;
  assign accept   = in_valid && !in_stall;
  assign keep     = in_data.mode != MODE_NONE;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    tsh_nxt   = tsh_r;
    tag_nxt   = tag_r;
    mode_nxt  = mode_r;
    l1_nxt    = l1_r;
    push      = 1'b0;
    push_data = '0;
    part      = {rem_r, tsh_r[TSH_W-1 -: DIG]};
    for (int k = DIG - 1; k >= 0; k--) begin
      if (part >= (PART_W'(SETS) << k)) begin
        part = part - (PART_W'(SETS) << k);
      end
    end
    if (SETS_POW2) begin
      push = accept && keep;
      push_data = {in_data.mode, in_data.l1_state != L1_INVALID, tag,
                   (SETS == 1) ? SET_W'(0) : tag[SET_W-1:0]};
    end else if (busy_r) begin
      rem_nxt = part[SET_W-1:0];
      tsh_nxt = tsh_r << DIG;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt  = 1'b0;
        push      = 1'b1;
        push_data = {mode_r, l1_r, tag_r, part[SET_W-1:0]};
      end
    end else if (accept && keep) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      rem_nxt  = '0;
      tsh_nxt  = TSH_W'(tag);
      tag_nxt  = tag;
      mode_nxt = in_data.mode;
      l1_nxt   = in_data.l1_state != L1_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    tsh_r  <= tsh_nxt;
    tag_r  <= tag_nxt;
    mode_r <= mode_nxt;
    l1_r   <= l1_nxt;
  end

endmodule

### rtl/amonf_queue.sv
module amonf_queue import amonf_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

### rtl/amonf_back.sv
module amonf_back import amonf_pkg::*; #(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS,
  parameter int CONF_BITS = DEF_CONF_BITS,
  parameter int TOTAL_BITS = DEF_TOTAL_BITS,
  localparam int TAG_W = ADDR_BITS - 1,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int QW = 3 + TAG_W + SET_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  logic [QW-1:0] pop_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data
);

  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [CONF_BITS-1:0]  CONF_MAX  = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EVAL = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [WAYS-1:0][TAG_W-1:0]     tag_mem  [SETS];
  logic [WAYS-1:0][CONF_BITS-1:0] conf_mem [SETS];
  logic [WAYS-1:0]                seen_mem [SETS];
  logic [WAYS-1:0][AGE_W-1:0]     age_mem  [SETS];
  logic [WAYS-1:0]                valid_r  [SETS];
  logic [SETS-1:0]                aged_r;

  logic [WAYS-1:0][TAG_W-1:0]     tag_rd_r;
  logic [WAYS-1:0][CONF_BITS-1:0] conf_rd_r;
  logic [WAYS-1:0]                seen_rd_r;
  logic [WAYS-1:0][AGE_W-1:0]     age_rd_r;

  logic [1:0]       mode_r;
  logic             l1_r;
  logic [TAG_W-1:0] tag_r;
  logic [SET_W-1:0] set_r;

  logic [TOTAL_BITS-1:0] fetched_r, fetched_nxt, reused_r, reused_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [WAYS-1:0]                vrow, vrow_new;
  logic [WAYS-1:0][AGE_W-1:0]     arow, arow_new;
  logic [WAYS-1:0][TAG_W-1:0]     trow_new;
  logic [WAYS-1:0][CONF_BITS-1:0] crow_new;
  logic [WAYS-1:0]                srow_new;
  logic             hit, found, we, near, bump_f, bump_r, halve;
  logic [AGE_W-1:0] hway, vict, sel, old;
  logic [TOTAL_BITS:0] half_up;

  assign pop       = (state_r == B_IDLE) && !empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    vrow = valid_r[set_r];
    for (int w = 0; w < WAYS; w++) begin
      arow[w] = aged_r[set_r] ? age_rd_r[w] : AGE_W'(w);
    end
    hit  = 1'b0;
    hway = '0;
    found = 1'b0;
    vict = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && tag_rd_r[w] == tag_r) begin
        hit  = 1'b1;
        hway = AGE_W'(w);
      end
      if (!vrow[w]) begin
        found = 1'b1;
        vict  = AGE_W'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (arow[w] == AGE_W'(WAYS - 1)) begin
          vict = AGE_W'(w);
        end
      end
    end
    sel = hit ? hway : vict;
    old = arow[sel];
    for (int w = 0; w < WAYS; w++) begin
      arow_new[w] = (arow[w] < old) ? arow[w] + 1'b1 : arow[w];
    end
    arow_new[sel] = '0;

    half_up  = {1'b0, fetched_r >> 1} + (TOTAL_BITS + 1)'(fetched_r[0]);
    vrow_new = vrow;
    trow_new = tag_rd_r;
    crow_new = conf_rd_r;
    srow_new = seen_rd_r;
    we       = 1'b0;
    near     = 1'b0;
    bump_f   = 1'b0;
    bump_r   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (state_r == B_EVAL) begin
      case (mode_r)
        MODE_PREDICT: begin
          we = 1'b1;
          if (!hit) begin
            near = (fetched_r == '0) || ({1'b0, reused_r} >= half_up);
            vrow_new[sel] = 1'b1;
            trow_new[sel] = tag_r;
            crow_new[sel] = CONF_MAX;
            srow_new[sel] = 1'b0;
          end else begin
            near = (conf_rd_r[sel] != '0) || l1_r;
            if (near) begin
              srow_new[sel] = 1'b0;
            end
          end
          bump_f = near;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{near: near, table_hit: hit};
        end
        MODE_HIT: begin
          we = hit;
          arow_new = arow;
          srow_new[sel] = 1'b1;
        end
        MODE_EVICT: begin
          we = hit;
          arow_new = arow;
          if (seen_rd_r[sel]) begin
            bump_r = hit;
            if (conf_rd_r[sel] != CONF_MAX) begin
              crow_new[sel] = conf_rd_r[sel] + 1'b1;
            end
          end else if (conf_rd_r[sel] != '0) begin
            crow_new[sel] = conf_rd_r[sel] - 1'b1;
          end
          srow_new[sel] = 1'b0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end

    halve = (bump_f || bump_r) && ((fetched_r == TOTAL_MAX) || (reused_r == TOTAL_MAX));
    fetched_nxt = halve ? fetched_r >> 1 : fetched_r;
    reused_nxt  = halve ? reused_r >> 1 : reused_r;
    if (bump_f) begin
      fetched_nxt = fetched_nxt + 1'b1;
    end
    if (bump_r) begin
      reused_nxt = reused_nxt + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      fetched_r   <= '0;
      reused_r    <= '0;
      aged_r      <= '0;
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fetched_r   <= fetched_nxt;
      reused_r    <= reused_nxt;
      if (we) begin
        valid_r[set_r] <= vrow_new;
        aged_r[set_r]  <= 1'b1;
      end
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {mode_r, l1_r, tag_r, set_r} <= pop_data;
      tag_rd_r  <= tag_mem[pop_data[SET_W-1:0]];
      conf_rd_r <= conf_mem[pop_data[SET_W-1:0]];
      seen_rd_r <= seen_mem[pop_data[SET_W-1:0]];
      age_rd_r  <= age_mem[pop_data[SET_W-1:0]];
    end
    if (we) begin
      tag_mem[set_r]  <= trow_new;
      conf_mem[set_r] <= crow_new;
      seen_mem[set_r] <= srow_new;
      age_mem[set_r]  <= arow_new;
    end
  end

endmodule

### rtl/amo_near_far_predictor.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | in_item_t: mode, address, l1_state
// out_    | output    | out_valid/out_stall | out_item_t: near, table_hit
// cfg_    | input     | cfg_valid/cfg_ready | block_offset_bits, 5 bits
// The table path moves each transaction through a queue hop, a row read and an
// evaluate-and-write step; the back end pops nothing new while it evaluates. With a
// non-power-of-two set count the front finds the set index by long division, four
// tag bits per step, stalling the input. Reset clears valid bits, counters and the
// queue. The result register lets the queue keep filling while out_stall is high.
module amo_near_far_predictor import amonf_pkg::*; #(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS,
  parameter int CONF_BITS = DEF_CONF_BITS,
  parameter int TOTAL_BITS = DEF_TOTAL_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OFFSET_W-1:0] cfg_data
);

  localparam int TAG_W = ADDR_BITS - 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int QW = 3 + TAG_W + SET_W;

  logic [OFFSET_W-1:0] offset_r;
  queue_ctl_t          qctl;
  logic [QW-1:0]       push_data, pop_data;
  logic                pop, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_data;
    end
  end

  amonf_front #(.SETS(SETS)) u_front (
    .clk, .rst_n, .offset(offset_r), .in_valid, .in_stall, .in_data,
    .push(qctl.push), .full(qctl.full), .push_data
  );

  amonf_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push(qctl.push), .push_data, .full(qctl.full),
    .pop, .empty, .pop_data
  );

  amonf_back #(
    .SETS(SETS), .WAYS(WAYS), .CONF_BITS(CONF_BITS), .TOTAL_BITS(TOTAL_BITS)
  ) u_back (
    .clk, .rst_n, .empty, .pop_data, .pop, .out_valid, .out_stall, .out_data
  );

endmodule

### rtl/amonf_checker.sv
`include "amo_near_far_predictor_macros.svh"

module amonf_checker import amonf_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input in_item_t            in_data,
  input logic                out_valid,
  input logic                out_stall,
  input out_item_t           out_data
);

  `AMONF_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "Result pending after reset.")
  `AMONF_ASSERT_ALWAYS(a_rst_in, !rst_n |=> !in_stall, "Input stalled after reset.")
  `AMONF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "Result dropped.")
  `AMONF_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "Result changed.")
  `AMONF_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_data), "Input moved.")

endmodule

bind amo_near_far_predictor amonf_checker u_chk (.*);

### bench/amonf_checker.sv
`timescale 1ns / 100ps
module amonf_scoreboard import amonf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [OFFSET_W-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);
  localparam int SETS = DEF_SETS;
  localparam int WAYS = DEF_WAYS;
  localparam int ENTRIES = SETS * WAYS;
  localparam logic [DEF_CONF_BITS-1:0] CONF_FULL = '1;
  localparam logic [DEF_TOTAL_BITS-1:0] TOTAL_FULL = '1;

  logic [OFFSET_W-1:0]      shift_cfg;
  logic [ADDR_BITS-1:0]     tag_mem [ENTRIES];
  logic                     vld_mem [ENTRIES];
  logic [DEF_CONF_BITS-1:0] conf_mem [ENTRIES];
  logic                     seen_mem [ENTRIES];
  int                       rank_mem [ENTRIES];
  logic [DEF_TOTAL_BITS-1:0] fetched_cnt, reused_cnt;
  out_item_t                placement_q[$];

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  task automatic count_up(input bit is_fetch);
    if (fetched_cnt == TOTAL_FULL || reused_cnt == TOTAL_FULL) begin
      fetched_cnt = fetched_cnt >> 1;
      reused_cnt = reused_cnt >> 1;
    end
    if (is_fetch) fetched_cnt++;
    else reused_cnt++;
  endtask

  task automatic touch(input int base, input int way);
    int old;
    old = rank_mem[base + way];
    for (int w = 0; w < WAYS; w++)
      if (rank_mem[base + w] < old) rank_mem[base + w]++;
    rank_mem[base + way] = 0;
  endtask

  task automatic predict_placement(input in_item_t it);
    int sh, base, way, victim, e;
    logic [ADDR_BITS-1:0] tag;
    out_item_t r;
    bit found;
    sh = shift_cfg;
    if (sh < 1) sh = 1;
    if (sh > 16) sh = 16;
    tag = it.address >> sh;
    base = (tag % SETS) * WAYS;
    way = -1;
    for (int w = WAYS - 1; w >= 0; w--)
      if (vld_mem[base + w] && tag_mem[base + w] == tag) way = w;
    if (it.mode == MODE_PREDICT) begin
      if (way < 0) begin
        r.near = (fetched_cnt == 0) || ({1'b0, reused_cnt, 1'b0} >= {2'b0, fetched_cnt});
        victim = 0;
        found = 0;
        for (int w = 0; w < WAYS; w++)
          if (!found && !vld_mem[base + w]) begin
            victim = w;
            found = 1;
          end
        if (!found)
          for (int w = 0; w < WAYS; w++)
            if (rank_mem[base + w] > rank_mem[base + victim]) victim = w;
        e = base + victim;
        vld_mem[e] = 1;
        tag_mem[e] = tag;
        conf_mem[e] = CONF_FULL;
        seen_mem[e] = 0;
        touch(base, victim);
        if (r.near) count_up(1);
        r.table_hit = 0;
      end else begin
        e = base + way;
        touch(base, way);
        if (conf_mem[e] != 0 || it.l1_state != L1_INVALID) begin
          seen_mem[e] = 0;
          count_up(1);
          r.near = 1;
        end else begin
          r.near = 0;
        end
        r.table_hit = 1;
      end
      placement_q.push_back(r);
    end else if (way >= 0) begin
      e = base + way;
      if (it.mode == MODE_HIT) begin
        seen_mem[e] = 1;
      end else if (it.mode == MODE_EVICT) begin
        if (seen_mem[e]) begin
          if (conf_mem[e] != CONF_FULL) conf_mem[e]++;
          count_up(0);
        end else if (conf_mem[e] != 0) begin
          conf_mem[e]--;
        end
        seen_mem[e] = 0;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      shift_cfg = OFFSET_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        vld_mem[i] = 0;
        rank_mem[i] = i % WAYS;
      end
      fetched_cnt = 0;
      reused_cnt = 0;
      placement_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) shift_cfg = cfg_data;
      if (in_valid && !in_stall) predict_placement(in_data);
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          out_item_t x;
          x = placement_q.pop_front();
          if (out_data.near !== x.near)
            report_mismatch($sformatf("near got %b want %b", out_data.near, x.near));
          if (out_data.table_hit !== x.table_hit)
            report_mismatch($sformatf("table_hit got %b want %b",
                                      out_data.table_hit, x.table_hit));
        end
      end
    end
    pending = placement_q.size();
  end
endmodule

### bench/tb.sv
`timescale 1ns / 100ps
module tb;
  import amonf_pkg::*;

  logic                clk, rst_n;
  logic                in_valid, in_stall, out_valid, out_stall;
  in_item_t            in_data;
  out_item_t           out_data;
  logic                cfg_valid, cfg_ready;
  logic [OFFSET_W-1:0] cfg_data;
  int                  fail_count, pending;
  int                  cycle_count;
  int                  send_idle, recv_stall;
  logic [ADDR_BITS-1:0] addr_pool [16];

  amo_near_far_predictor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  amonf_scoreboard chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic send_op(input logic [1:0] mode, input logic [ADDR_BITS-1:0] addr,
                         input logic [1:0] l1);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{mode: mode, address: addr, l1_state: l1};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] v);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    logic [1:0] mode;
    logic [ADDR_BITS-1:0] a;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < 16; i++) addr_pool[i] = rand_addr();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) a = rand_addr();
      else a = addr_pool[$urandom_range(15)] ^ ($urandom_range(3) << 10);
      mode = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
      send_op(mode, a, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    out_stall = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_op(MODE_PREDICT, '0, L1_INVALID);
    send_op(MODE_PREDICT, '1, 2'd3);
    send_op(MODE_PREDICT, '0, L1_INVALID);
    send_op(MODE_HIT, '0, L1_INVALID);
    send_op(MODE_EVICT, '0, L1_INVALID);
    send_op(MODE_EVICT, '0, L1_INVALID);
    send_op(MODE_EVICT, '0, L1_INVALID);
    send_op(MODE_EVICT, '0, L1_INVALID);
    send_op(MODE_EVICT, '0, L1_INVALID);
    send_op(MODE_PREDICT, '0, L1_INVALID);
    send_op(MODE_PREDICT, '0, 2'd1);
    send_op(MODE_PREDICT, '0, 2'd2);
    send_op(MODE_NONE, '1, 2'd3);
    send_op(MODE_HIT, 48'h1234_0000_0000, L1_INVALID);
    for (int i = 0; i < 6; i++)
      send_op(MODE_PREDICT, 48'(i) << 12, L1_INVALID);
    send_op(MODE_EVICT, 48'h5555_5555_5555, L1_INVALID);

    random_phase(300, 0, 0);
    write_offset(5'd0);
    random_phase(250, 50, 0);
    write_offset(5'd31);
    random_phase(250, 0, 50);
    write_offset(5'd16);
    random_phase(250, 27, 27);
    write_offset(5'd1);
    random_phase(200, 0, 0);
    write_offset(5'd12);
    random_phase(200, 27, 27);

    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    recv_stall = 0;
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### amo_near_far_predictor.f
+incdir+rtl
rtl/amonf_pkg.sv
rtl/amonf_front.sv
rtl/amonf_queue.sv
rtl/amonf_back.sv
rtl/amo_near_far_predictor.sv
rtl/amonf_checker.sv
bench/amonf_checker.sv
bench/tb.sv
